@@ rtl/hq_pkg.sv @@
// Shared types, constants and helpers for the histogram equalizer.
// No dependencies; the top level and hq_div import it.
package hq_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int LUMA_BINS  = 256;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int STORE_AW   = $clog2(STORE_DEPTH);
    localparam int BIN_AW     = $clog2(LUMA_BINS);
    localparam int CNT_W      = STORE_AW + 1;
    localparam int SIZE_W     = 9;

    localparam int DIVIDEND_W = 24;
    localparam int DIVISOR_W  = CNT_W;
    localparam int QUO_W      = 10;
    localparam int REM_W      = DIVISOR_W + QUO_W - 1;
    localparam int DCNT_W     = $clog2(QUO_W);

    // x / 1000 == (x * CSC_RECIP) >> CSC_SHIFT, exact for x below 2^22
    localparam int                  CSC_MAG_W = 20;
    localparam logic [CSC_MAG_W-1:0] CSC_RECIP = CSC_MAG_W'(536871);
    localparam int                  CSC_SHIFT = 29;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_FRAME = 2'd1;
    localparam logic [1:0] ST_RANGE    = 2'd2;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_READ = 1'b1;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DIV, S_DWAIT, S_LD_STORE, S_LD_HIST,
        S_MAP_RD, S_MAP_ACC, S_MAP_WAIT, S_RD_PIX, S_RD_MAP, S_OUT
    } t_state;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quo;
    } t_div_rsp;

    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] max);
        if (v == '0) return SIZE_W'(1);
        return (v > max) ? max : v;
    endfunction

    function automatic logic [7:0] clamp8(input logic signed [QUO_W:0] v);
        if (v < 0) return 8'd0;
        if (v > 255) return 8'd255;
        return v[7:0];
    endfunction

endpackage

@@ rtl/histogram_equalize_rgb_frame.sv @@
// Histogram equalizer top level: sequencer, pixel store, histogram, luma map.
// Depends on hq_pkg, hq_ram and hq_div.
// After reset every histogram bin is cleared; no item is taken then.
// One item at a time. After a load is taken the input is held off for three
// divisions by 1000 (each a reciprocal multiply); a load that ends a frame
// adds the map build on the divider, one division per luma bin.
// A read is offered after its divisions (in the next cycle when only a status is
// returned) and holds until that result is taken.
module histogram_equalize_rgb_frame (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_index,
    input  logic [hq_pkg::SIZE_W-1:0]  i_cfg_data,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [39:0]                s_axis_tdata,  // red, green, blue, pixel_index
    input  logic                       s_axis_tuser,  // req_type
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [31:0]                m_axis_tdata   // red, green, blue, status
);
    import hq_pkg::*;

    t_state r_state, n_state;

    logic [SIZE_W-1:0]  r_width, r_height;
    logic [CNT_W-1:0]   r_load_cnt, r_ftotal, r_cum;
    logic               r_ready, r_mode;
    logic [BIN_AW-1:0]  r_bin;
    logic [1:0]         r_step;
    logic               r_neg;
    logic [CSC_MAG_W-1:0] r_mag;
    logic [7:0]         r_c0, r_c1, r_c2;
    logic signed [QUO_W:0] r_q0, r_q1, r_q2;
    logic [23:0]        r_out;
    logic [1:0]         r_stat;

    t_div_req w_req;
    t_div_rsp w_rsp;

    logic                  hist_we;
    logic [BIN_AW-1:0]     hist_waddr, hist_raddr;
    logic [CNT_W-1:0]      hist_wdata, hist_rdata;
    logic                  pix_we;
    logic [23:0]           pix_wdata, pix_rdata;
    logic                  map_we;
    logic [7:0]            map_wdata, map_rdata;

    logic                  w_accept;
    logic [CNT_W-1:0]      w_next_cnt, w_total, w_cum;
    logic                  w_complete;
    logic [7:0]            w_y8, w_cb8, w_cr8;
    logic [2*CSC_MAG_W-1:0] w_prod;
    logic signed [QUO_W:0] w_qs;
    int                    num;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = {6'd0, r_stat, r_out};

    assign w_next_cnt = r_load_cnt + CNT_W'(1);
    assign w_total    = CNT_W'(eff_size(r_width, SIZE_W'(MAX_WIDTH))) *
                        CNT_W'(eff_size(r_height, SIZE_W'(MAX_HEIGHT)));
    assign w_complete = (w_next_cnt >= w_total);
    assign w_cum      = r_cum + hist_rdata;
    assign w_y8       = r_q0[7:0] + 8'd16;
    assign w_cb8      = r_q1[7:0] + 8'd128;
    assign w_cr8      = r_q2[7:0] + 8'd128;
    assign w_prod     = r_mag * CSC_RECIP;
    assign w_qs       = r_neg ? -{1'b0, w_prod[CSC_SHIFT +: QUO_W]} :
                                {1'b0, w_prod[CSC_SHIFT +: QUO_W]};

    // numerator of the current division by 1000
    always_comb begin
        int a0, a1, a2;
        a0 = int'(r_c0);
        a1 = int'(r_c1);
        a2 = int'(r_c2);
        num = 0;
        if (r_mode == REQ_LOAD) begin
            case (r_step)
                2'd0:    num = 257 * a0 + 504 * a1 + 98 * a2;
                2'd1:    num = -148 * a0 - 291 * a1 + 439 * a2;
                default: num = 439 * a0 - 368 * a1 - 71 * a2;
            endcase
        end else begin
            a0 = a0 - 16;
            a1 = a1 - 128;
            a2 = a2 - 128;
            case (r_step)
                2'd0:    num = 1164 * a0 + 1596 * a2;
                2'd1:    num = 1164 * a0 - 392 * a1 - 813 * a2;
                default: num = 1164 * a0 + 2017 * a1;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR:    if (r_bin == BIN_AW'(LUMA_BINS - 1)) n_state = S_IDLE;
            S_IDLE: begin
                if (w_accept) begin
                    if (s_axis_tuser == REQ_LOAD) n_state = S_DIV;
                    else if (!r_ready) n_state = S_OUT;
                    else if (CNT_W'(s_axis_tdata[39:24]) >= r_ftotal) n_state = S_OUT;
                    else n_state = S_RD_PIX;
                end
            end
            S_DIV:      n_state = S_DWAIT;
            S_DWAIT: begin
                if (r_step != 2'd2) n_state = S_DIV;
                else if (r_mode == REQ_LOAD) n_state = S_LD_STORE;
                else n_state = S_OUT;
            end
            S_LD_STORE: n_state = S_LD_HIST;
            S_LD_HIST:  n_state = w_complete ? S_MAP_RD : S_IDLE;
            S_MAP_RD:   n_state = S_MAP_ACC;
            S_MAP_ACC:  n_state = S_MAP_WAIT;
            S_MAP_WAIT: begin
                if (w_rsp.done) begin
                    n_state = (r_bin == BIN_AW'(LUMA_BINS - 1)) ? S_IDLE : S_MAP_RD;
                end
            end
            S_RD_PIX:   n_state = S_RD_MAP;
            S_RD_MAP:   n_state = S_DIV;
            S_OUT:      if (m_axis_tready) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // memory and divider controls
    always_comb begin
        hist_we    = 1'b0;
        hist_waddr = r_bin;
        hist_wdata = '0;
        hist_raddr = r_bin;
        pix_we     = 1'b0;
        pix_wdata  = {w_y8, w_cb8, w_cr8};
        map_we     = 1'b0;
        map_wdata  = w_rsp.quo[7:0] + 8'd16;
        w_req.start    = 1'b0;
        w_req.divisor  = r_ftotal;
        w_req.dividend = '0;
        case (r_state)
            S_CLEAR:    hist_we = 1'b1;
            S_LD_STORE: begin
                pix_we     = !r_load_cnt[CNT_W-1];
                hist_raddr = w_y8;
            end
            S_LD_HIST: begin
                hist_we    = 1'b1;
                hist_waddr = w_y8;
                hist_wdata = hist_rdata + CNT_W'(1);
            end
            S_MAP_ACC: begin
                hist_we        = 1'b1;
                w_req.start    = 1'b1;
                w_req.dividend = DIVIDEND_W'(DIVIDEND_W'(w_cum) * DIVIDEND_W'(219));
            end
            S_MAP_WAIT: map_we = w_rsp.done;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_width    <= SIZE_W'(MAX_WIDTH);
            r_height   <= SIZE_W'(MAX_HEIGHT);
            r_load_cnt <= '0;
            r_ftotal   <= '0;
            r_ready    <= 1'b0;
            r_bin      <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_WIDTH) r_width <= i_cfg_data;
                else r_height <= i_cfg_data;
            end
            case (r_state)
                S_CLEAR:   r_bin <= r_bin + BIN_AW'(1);
                S_LD_HIST: begin
                    if (w_complete) begin
                        r_ftotal   <= w_next_cnt;
                        r_load_cnt <= '0;
                    end else begin
                        r_load_cnt <= w_next_cnt;
                        r_ready    <= 1'b0;
                    end
                end
                S_MAP_WAIT: begin
                    if (w_rsp.done) begin
                        r_bin <= r_bin + BIN_AW'(1);
                        if (r_bin == BIN_AW'(LUMA_BINS - 1)) r_ready <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_step <= 2'd0;
                r_mode <= s_axis_tuser;
                r_c0   <= s_axis_tdata[7:0];
                r_c1   <= s_axis_tdata[15:8];
                r_c2   <= s_axis_tdata[23:16];
                r_out  <= '0;
                r_cum  <= '0;
                r_stat <= r_ready ? ST_RANGE : ST_NO_FRAME;
            end
            S_DIV: begin
                r_neg <= (num < 0);
                r_mag <= CSC_MAG_W'((num < 0) ? -num : num);
            end
            S_DWAIT: begin
                case (r_step)
                    2'd0:    r_q0 <= w_qs;
                    2'd1:    r_q1 <= w_qs;
                    default: r_q2 <= w_qs;
                endcase
                r_step <= r_step + 2'd1;
                if (r_step == 2'd2) begin
                    r_out  <= {clamp8(w_qs), clamp8(r_q1), clamp8(r_q0)};
                    r_stat <= ST_OK;
                end
            end
            S_MAP_ACC: r_cum <= w_cum;
            S_RD_PIX: begin
                r_c1 <= pix_rdata[15:8];
                r_c2 <= pix_rdata[7:0];
            end
            S_RD_MAP:  r_c0 <= map_rdata;
            default: ;
        endcase
    end

    hq_ram #(.W(24), .D(STORE_DEPTH)) u_pix (
        .i_clk   (i_clk),
        .i_we    (pix_we),
        .i_waddr (r_load_cnt[STORE_AW-1:0]),
        .i_wdata (pix_wdata),
        .i_raddr (s_axis_tdata[39:24]),
        .o_rdata (pix_rdata)
    );

    hq_ram #(.W(CNT_W), .D(LUMA_BINS)) u_hist (
        .i_clk   (i_clk),
        .i_we    (hist_we),
        .i_waddr (hist_waddr),
        .i_wdata (hist_wdata),
        .i_raddr (hist_raddr),
        .o_rdata (hist_rdata)
    );

    hq_ram #(.W(8), .D(LUMA_BINS)) u_map (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (r_bin),
        .i_wdata (map_wdata),
        .i_raddr (pix_rdata[23:16]),
        .o_rdata (map_rdata)
    );

    hq_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );
endmodule

@@ rtl/hq_ram.sv @@
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module hq_ram #(
    parameter int W = 8,
    parameter int D = 256
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/hq_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Depends on hq_pkg.
module hq_div (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  hq_pkg::t_div_req i_req,
    output hq_pkg::t_div_rsp o_rsp
);
    import hq_pkg::*;

    logic [REM_W-1:0]  r_rem;
    logic [REM_W-1:0]  r_dsh;
    logic [QUO_W-1:0]  r_quo;
    logic [DCNT_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;
    logic              w_ge;

    assign w_ge = (r_rem >= r_dsh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == DCNT_W'(QUO_W - 1));
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == DCNT_W'(QUO_W - 1))) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= REM_W'(i_req.dividend);
            r_dsh <= {i_req.divisor, (QUO_W-1)'(0)};
            r_quo <= '0;
            r_cnt <= '0;
        end else if (r_busy) begin
            if (w_ge) begin
                r_rem <= r_rem - r_dsh;
            end
            r_quo <= {r_quo[QUO_W-2:0], w_ge};
            r_dsh <= r_dsh >> 1;
            r_cnt <= r_cnt + DCNT_W'(1);
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
endmodule

@@ test/tb.sv @@
// Testbench for histogram_equalize_rgb_frame: random frames of RGB loads and readbacks.
// Predicts each readback from its own model of store, histogram and luma map.
// Depends on hq_pkg and the rtl files.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic      req;
        bit [7:0]  red;
        bit [7:0]  green;
        bit [7:0]  blue;
        bit [15:0] idx;
    } pix_req_t;

    typedef struct {
        bit [7:0] red;
        bit [7:0] green;
        bit [7:0] blue;
        bit [1:0] status;
    } eq_pix_t;

    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int SETTLE_CYCLES = 4000;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_cfg_we = 1'b0;
    logic                        i_cfg_index = 1'b0;
    logic [hq_pkg::SIZE_W-1:0]   i_cfg_data = '0;
    logic                        s_axis_tvalid = 1'b0;
    logic                        s_axis_tready;
    logic [39:0]                 s_axis_tdata = '0;  // red, green, blue, pixel_index
    logic                        s_axis_tuser = 1'b0;  // req_type
    logic                        m_axis_tvalid;
    logic                        m_axis_tready = 1'b0;
    logic [31:0]                 m_axis_tdata;  // red, green, blue, status

    histogram_equalize_rgb_frame u_dut (.*);

    always #5 i_clk = ~i_clk;

    // predictor state
    bit [23:0] ycc_store [65536];
    int        luma_hist [256];
    bit [7:0]  luma_lut [256];
    int        fill_cnt;
    bit        frame_held;
    int        held_total;
    bit [8:0]  width_reg = 9'd256;
    bit [8:0]  height_reg = 9'd256;

    pix_req_t  pend_q[$];
    eq_pix_t   eq_pix_q[$];
    pix_req_t  cur;
    bit        quiet;
    int        src_gap;
    int        sink_gap;
    int        n_err;
    int        cycles;

    function automatic int fit_size(bit [8:0] v, int max);
        if (v == 0) return 1;
        return (v > max) ? max : int'(v);
    endfunction

    function automatic bit [7:0] sat8(int v);
        if (v < 0) return 8'd0;
        if (v > 255) return 8'd255;
        return v[7:0];
    endfunction

    function automatic int frame_size();
        return fit_size(width_reg, hq_pkg::MAX_WIDTH) * fit_size(height_reg, hq_pkg::MAX_HEIGHT);
    endfunction

    function automatic void predict_equalize(pix_req_t it);
        int r, g, b, y, cb, cr, cum;
        bit [23:0] px;
        eq_pix_t res;
        r = it.red;
        g = it.green;
        b = it.blue;
        if (it.req == hq_pkg::REQ_LOAD) begin
            y  = (257 * r + 504 * g + 98 * b) / 1000 + 16;
            cb = (-148 * r - 291 * g + 439 * b) / 1000 + 128;
            cr = (439 * r - 368 * g - 71 * b) / 1000 + 128;
            if (fill_cnt < 65536) ycc_store[fill_cnt] = {y[7:0], cb[7:0], cr[7:0]};
            luma_hist[y[7:0]]++;
            fill_cnt++;
            if (fill_cnt >= frame_size()) begin
                cum = 0;
                for (int i = 0; i < 256; i++) begin
                    cum += luma_hist[i];
                    luma_lut[i] = 8'((219 * cum) / fill_cnt + 16);
                    luma_hist[i] = 0;
                end
                held_total = fill_cnt;
                frame_held = 1'b1;
                fill_cnt = 0;
            end else begin
                frame_held = 1'b0;
            end
        end else begin
            res = '{8'd0, 8'd0, 8'd0, hq_pkg::ST_OK};
            if (!frame_held) begin
                res.status = hq_pkg::ST_NO_FRAME;
            end else if (it.idx >= held_total) begin
                res.status = hq_pkg::ST_RANGE;
            end else begin
                px = ycc_store[it.idx];
                y  = int'(luma_lut[px[23:16]]) - 16;
                cb = int'(px[15:8]) - 128;
                cr = int'(px[7:0]) - 128;
                res.red   = sat8((1164 * y + 1596 * cr) / 1000);
                res.green = sat8((1164 * y - 392 * cb - 813 * cr) / 1000);
                res.blue  = sat8((1164 * y + 2017 * cb) / 1000);
            end
            eq_pix_q.push_back(res);
        end
    endfunction

    // source side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            src_gap = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) predict_equalize(cur);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (pend_q.size() > 0) begin
                    if (!quiet && $urandom_range(0, 9) == 0) begin
                        src_gap = $urandom_range(1, 8) - 1;
                        s_axis_tvalid <= 1'b0;
                    end else begin
                        cur = pend_q.pop_front();
                        s_axis_tvalid <= 1'b1;
                        s_axis_tdata  <= {cur.idx, cur.blue, cur.green, cur.red};
                        s_axis_tuser  <= cur.req;
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // sink side
    always @(posedge i_clk) begin
        eq_pix_t want;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (eq_pix_q.size() == 0) begin
                n_err++;
                if (n_err <= 10) $display("unexpected item %h", m_axis_tdata);
            end else begin
                want = eq_pix_q.pop_front();
                if (m_axis_tdata != {6'd0, want.status, want.blue, want.green, want.red}) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("mismatch: exp st=%0d r=%0d g=%0d b=%0d, got st=%0d r=%0d g=%0d b=%0d",
                                 want.status, want.red, want.green, want.blue,
                                 m_axis_tdata[25:24], m_axis_tdata[7:0],
                                 m_axis_tdata[15:8], m_axis_tdata[23:16]);
                end
            end
        end
        if (sink_gap > 0) begin
            sink_gap--;
            m_axis_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            sink_gap = $urandom_range(1, 8) - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic set_size(bit [8:0] w, bit [8:0] h);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= hq_pkg::CFG_WIDTH;
        i_cfg_data  <= w;
        width_reg = w;
        @(posedge i_clk);
        i_cfg_index <= hq_pkg::CFG_HEIGHT;
        i_cfg_data  <= h;
        height_reg = h;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic settle();
        while (pend_q.size() > 0 || s_axis_tvalid || eq_pix_q.size() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic void push_load(bit [7:0] r, bit [7:0] g, bit [7:0] b);
        pend_q.push_back('{hq_pkg::REQ_LOAD, r, g, b, 16'($urandom)});
    endfunction

    function automatic void push_read(bit [15:0] idx);
        pend_q.push_back('{hq_pkg::REQ_READ, 8'($urandom), 8'($urandom), 8'($urandom), idx});
    endfunction

    function automatic void push_rand_load();
        push_load(8'($urandom), 8'($urandom), 8'($urandom));
    endfunction

    initial begin
        int n_items, tot, nl, nr, sel;
        bit [8:0] w, h;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // no frame yet, then a frame closed by shrinking the size mid-frame
        push_read(16'd0);
        push_read(16'hFFFF);
        push_load(8'd0, 8'd0, 8'd0);
        push_load(8'd255, 8'd255, 8'd255);
        push_load(8'd255, 8'd0, 8'd0);
        push_load(8'd0, 8'd255, 8'd0);
        push_load(8'd0, 8'd0, 8'd255);
        push_read(16'd2);
        settle();
        set_size(9'd0, 9'd0);
        push_load(8'd0, 8'd255, 8'd255);
        for (int i = 0; i <= 7; i++) push_read(16'(i));
        push_read(16'hFFFF);
        settle();
        // a load that leaves a frame open drops the held one
        set_size(9'd2, 9'd1);
        push_load(8'd128, 8'd64, 8'd32);
        push_read(16'd0);
        push_load(8'd10, 8'd200, 8'd90);
        push_read(16'd1);
        push_read(16'd2);
        settle();
        // oversized register values
        set_size(9'd511, 9'd1);
        for (int i = 0; i < 256; i++) push_rand_load();
        push_read(16'd0);
        push_read(16'd255);
        push_read(16'd256);
        settle();
        set_size(9'd1, 9'd511);
        for (int i = 0; i < 256; i++) push_load(8'(i), 8'(255 - i), 8'(i * 7));
        push_read(16'd128);
        settle();
        set_size(9'd256, 9'd1);
        n_items = 520;

        while (n_items < 700) begin
            quiet = (n_items >= 640);
            sel = $urandom_range(0, 19);
            if (sel == 0) begin
                w = 9'd256;
                h = 9'($urandom_range(0, 1));
            end else if (sel == 1) begin
                w = 9'd0;
                h = 9'($urandom_range(0, 6));
            end else begin
                w = 9'($urandom_range(1, 4));
                h = 9'($urandom_range(1, 4));
            end
            settle();
            set_size(w, h);
            tot = frame_size();
            for (int f = $urandom_range(1, 3); f > 0; f--) begin
                nl = (fill_cnt < tot) ? tot - fill_cnt : 1;
                if ($urandom_range(0, 9) == 0) nl = $urandom_range(1, nl);
                for (int i = 0; i < nl; i++) begin
                    if ($urandom_range(0, 15) == 0) begin
                        push_read(16'($urandom));
                        n_items++;
                    end
                    push_rand_load();
                end
                n_items += nl;
                nr = $urandom_range(1, 12);
                for (int i = 0; i < nr; i++) begin
                    sel = $urandom_range(0, 9);
                    if (sel < 8) push_read(16'($urandom_range(0, tot - 1)));
                    else if (sel == 8) push_read(16'(tot + $urandom_range(0, 3)));
                    else push_read(16'($urandom));
                end
                n_items += nr;
                // fill_cnt is kept, so partial frames carry over into the next phase
                fill_cnt = fill_cnt;
            end
        end

        while (pend_q.size() > 0 || s_axis_tvalid || eq_pix_q.size() > 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (n_err == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
